@@ hw/rtl/drtr_pkg.sv @@
// Shared types and constants for the dual ratio test ranging block.
// No dependencies.
`timescale 1ns / 1ps

package drtr_pkg;

    localparam int WORD_W = 64;
    localparam int TOL_W  = 41;
    localparam int IDX_W  = 16;
    localparam int NUM_W  = 66;

    localparam logic [WORD_W-1:0] FIX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] FIX_MIN = 64'h8000_0000_0000_0000;

    localparam logic [TOL_W-1:0] DUAL_TOL_RST  = 41'd109951163;
    localparam logic [TOL_W-1:0] PIVOT_TOL_RST = 41'd109951;

    localparam logic [7:0] REG_DUAL_TOL  = 8'd0;
    localparam logic [7:0] REG_PIVOT_TOL = 8'd1;

    typedef enum logic [2:0] {
        ST_BASIC      = 3'd0,
        ST_FIXED      = 3'd1,
        ST_FREE       = 3'd2,
        ST_SUPERBASIC = 3'd3,
        ST_AT_UPPER   = 3'd4,
        ST_AT_LOWER   = 3'd5
    } var_status_t;

endpackage

@@ hw/rtl/drtr_mul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on drtr_pkg.
`timescale 1ns / 1ps

module drtr_mul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [drtr_pkg::WORD_W-1:0]     a,
    input  logic [drtr_pkg::WORD_W-1:0]     b,
    output logic                            done,
    output logic [2*drtr_pkg::WORD_W-1:0]   prod
);

    localparam int W  = drtr_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [W:0]    sum;

    assign done = busy_reg && (cnt_reg == CW'(W - 1));
    assign prod = {hi_reg, lo_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg + CW'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

endmodule

@@ hw/rtl/drtr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on drtr_pkg.
`timescale 1ns / 1ps

module drtr_div
#(
    parameter int NW = 106
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NW-1:0]               dividend,
    input  logic [drtr_pkg::WORD_W-1:0] divisor,
    output logic                        done,
    output logic [NW-1:0]               quot
);

    localparam int W  = drtr_pkg::WORD_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  r_reg, r_next;
    logic [NW-1:0] dv_reg, dv_next;
    logic [NW-1:0] q_reg, q_next;
    logic [W:0]    rs;
    logic          ge;

    assign done = busy_reg && (cnt_reg == CW'(NW - 1));
    assign quot = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        rs        = {r_reg, dv_reg[NW-1]};
        ge        = rs >= {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            d_next    = divisor;
            r_next    = '0;
            dv_next   = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? W'(rs - {1'b0, d_reg}) : rs[W-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            dv_next  = {dv_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        r_reg  <= r_next;
        dv_reg <= dv_next;
        q_reg  <= q_next;
    end

endmodule

@@ hw/rtl/dual_ratio_test_ranging.sv @@
// Top level of the two-sided dual ratio test used for cost ranging.
// Depends on drtr_pkg, drtr_mul and drtr_div.
`timescale 1ns / 1ps

// One pivot-row element is taken per item and processed alone. s_tready
// stays low until that element is done. An element that is skipped,
// changes nothing by its status, or forces both steps to zero goes from
// S_PREP straight to S_FIN. An element at a bound runs the shift-add
// multiplier for the ratio check in S_MUL, then S_NEG and S_CHK. When it
// does not tighten a step it goes on to S_FIN. When it tightens one, the
// one-bit-per-cycle divider runs in S_DIV before S_FIX. A tightening with
// a zero numerator or zero alpha bypasses the divider and goes from S_CHK
// straight to S_FIX. The result of the last element sits in an output
// register, so the next row may start while it waits. A last element that
// finds that register still full holds until it drains.

module dual_ratio_test_ranging
#(
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 40
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_addr,
    input  logic [40:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // alpha, reduced_cost, var_index
    input  logic [2:0]   s_tuser,   // var_status
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // step_up, up_index, up_found,
                                    // step_down, down_index, down_found, pad
);

    localparam int W   = drtr_pkg::WORD_W;
    localparam int PW  = 2 * W;
    localparam int NW  = drtr_pkg::NUM_W;
    localparam int DVW = NW + FRAC_BITS;
    localparam int IW  = (INDEX_BITS < drtr_pkg::IDX_W) ? INDEX_BITS : drtr_pkg::IDX_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_NEG  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIX  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [drtr_pkg::TOL_W-1:0] dtol_reg, dtol_next;
    logic [drtr_pkg::TOL_W-1:0] ptol_reg, ptol_next;
    logic [W-1:0]  up_theta_reg, up_theta_next;
    logic [W-1:0]  dn_theta_reg, dn_theta_next;
    logic [IW-1:0] up_seq_reg, up_seq_next;
    logic [IW-1:0] dn_seq_reg, dn_seq_next;
    logic          up_ok_reg, up_ok_next;
    logic          dn_ok_reg, dn_ok_next;
    logic          m_valid_reg, m_valid_next;
    logic [167:0]  m_data_reg, m_data_next;

    logic [W-1:0]          alpha_reg;
    logic [W-1:0]          dj_reg;
    logic [2:0]            status_reg;
    logic [IW-1:0]         idx_reg;
    logic                  last_reg;
    logic [W-1:0]          amag_reg, amag_next;
    logic                  aneg_reg, aneg_next;
    logic                  sel_up_reg, sel_up_next;
    logic                  nltp_reg, nltp_next;
    logic signed [NW-1:0]  num_reg, num_next;
    logic signed [PW-1:0]  p_reg, p_next;
    logic signed [PW-1:0]  nsh_reg, nsh_next;
    logic [NW-1:0]         nmag_reg, nmag_next;

    logic                  accept;
    logic                  apos, elig;
    logic signed [NW-1:0]  tol_x, dj_x;
    logic [W-1:0]          theta_sel;
    logic [W-1:0]          tmag;
    logic                  mul_start, mul_done;
    logic [PW-1:0]         mul_prod;
    logic                  div_start, div_done;
    logic [DVW-1:0]        div_q;
    logic                  hit, nneg, qneg, ovf;
    logic [W-1:0]          lim, ql, res;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    drtr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (tmag),
        .b     (amag_next),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    drtr_div #(.NW(DVW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVW'(nmag_reg) << FRAC_BITS),
        .divisor  (amag_reg),
        .done     (div_done),
        .quot     (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        dtol_next     = dtol_reg;
        ptol_next     = ptol_reg;
        up_theta_next = up_theta_reg;
        dn_theta_next = dn_theta_reg;
        up_seq_next   = up_seq_reg;
        dn_seq_next   = dn_seq_reg;
        up_ok_next    = up_ok_reg;
        dn_ok_next    = dn_ok_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        aneg_next     = alpha_reg[W-1];
        amag_next     = aneg_next ? (W'(0) - alpha_reg) : alpha_reg;
        sel_up_next   = sel_up_reg;
        nltp_next     = nltp_reg;
        num_next      = num_reg;
        p_next        = p_reg;
        nsh_next      = nsh_reg;
        nmag_next     = nmag_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;

        apos  = !alpha_reg[W-1] && (alpha_reg != '0);
        elig  = amag_next >= W'(ptol_reg);
        tol_x = NW'($signed({1'b0, dtol_reg}));
        dj_x  = NW'($signed(dj_reg));
        theta_sel = sel_up_next ? up_theta_reg : dn_theta_reg;
        tmag  = theta_sel[W-1] ? (W'(0) - theta_sel) : theta_sel;

        hit  = nltp_reg ? (nsh_reg < p_reg) : (p_reg < nsh_reg);
        nneg = num_reg[NW-1];
        qneg = nneg != aneg_reg;
        lim  = qneg ? drtr_pkg::FIX_MIN : drtr_pkg::FIX_MAX;
        ovf  = (|div_q[DVW-1:W]) || (div_q[W-1:0] > lim);
        ql   = ovf ? lim : div_q[W-1:0];
        res  = qneg ? (W'(0) - ql) : ql;
        if (nmag_reg == '0)
        begin
            res = '0;
        end
        else if (amag_reg == '0)
        begin
            res = nneg ? drtr_pkg::FIX_MIN : drtr_pkg::FIX_MAX;
        end

        if (cfg_we)
        begin
            if (cfg_addr == drtr_pkg::REG_DUAL_TOL)
            begin
                dtol_next = cfg_data;
            end
            else if (cfg_addr == drtr_pkg::REG_PIVOT_TOL)
            begin
                ptol_next = cfg_data;
            end
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_FIN;
                if (elig)
                begin
                    case (status_reg)
                        drtr_pkg::ST_FREE, drtr_pkg::ST_SUPERBASIC:
                        begin
                            up_theta_next = '0;
                            dn_theta_next = '0;
                            up_seq_next   = idx_reg;
                            dn_seq_next   = idx_reg;
                            up_ok_next    = 1'b1;
                            dn_ok_next    = 1'b1;
                        end
                        drtr_pkg::ST_AT_UPPER:
                        begin
                            sel_up_next = apos;
                            nltp_next   = apos;
                            num_next    = apos ? (tol_x - dj_x) : (dj_x - tol_x);
                            theta_sel   = apos ? up_theta_reg : dn_theta_reg;
                            tmag        = theta_sel[W-1] ? (W'(0) - theta_sel) : theta_sel;
                            mul_start   = 1'b1;
                            state_next  = S_MUL;
                        end
                        drtr_pkg::ST_AT_LOWER:
                        begin
                            sel_up_next = aneg_next;
                            nltp_next   = !aneg_next;
                            num_next    = aneg_next ? (-tol_x - dj_x) : (tol_x + dj_x);
                            theta_sel   = aneg_next ? up_theta_reg : dn_theta_reg;
                            tmag        = theta_sel[W-1] ? (W'(0) - theta_sel) : theta_sel;
                            mul_start   = 1'b1;
                            state_next  = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_NEG;
                end
            end
            S_NEG:
            begin
                p_next    = (theta_sel[W-1] != aneg_reg) ? (PW'(0) - mul_prod) : mul_prod;
                nsh_next  = PW'(num_reg) <<< FRAC_BITS;
                nmag_next = num_reg[NW-1] ? (NW'(0) - num_reg) : num_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!hit)
                begin
                    state_next = S_FIN;
                end
                else if (nmag_reg == '0 || amag_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (sel_up_reg)
                begin
                    up_theta_next = res;
                    up_seq_next   = idx_reg;
                    up_ok_next    = 1'b1;
                end
                else
                begin
                    dn_theta_next = res;
                    dn_seq_next   = idx_reg;
                    dn_ok_next    = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {6'd0, dn_ok_reg, drtr_pkg::IDX_W'(dn_seq_reg),
                                     dn_theta_reg, up_ok_reg,
                                     drtr_pkg::IDX_W'(up_seq_reg), up_theta_reg};
                    up_theta_next = drtr_pkg::FIX_MAX;
                    dn_theta_next = drtr_pkg::FIX_MAX;
                    up_seq_next   = '0;
                    dn_seq_next   = '0;
                    up_ok_next    = 1'b0;
                    dn_ok_next    = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dtol_reg     <= drtr_pkg::DUAL_TOL_RST;
            ptol_reg     <= drtr_pkg::PIVOT_TOL_RST;
            up_theta_reg <= drtr_pkg::FIX_MAX;
            dn_theta_reg <= drtr_pkg::FIX_MAX;
            up_seq_reg   <= '0;
            dn_seq_reg   <= '0;
            up_ok_reg    <= 1'b0;
            dn_ok_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dtol_reg     <= dtol_next;
            ptol_reg     <= ptol_next;
            up_theta_reg <= up_theta_next;
            dn_theta_reg <= dn_theta_next;
            up_seq_reg   <= up_seq_next;
            dn_seq_reg   <= dn_seq_next;
            up_ok_reg    <= up_ok_next;
            dn_ok_reg    <= dn_ok_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            alpha_reg  <= s_tdata[63:0];
            dj_reg     <= s_tdata[127:64];
            idx_reg    <= s_tdata[128 +: IW];
            status_reg <= s_tuser;
            last_reg   <= s_tlast;
        end
        m_data_reg <= m_data_next;
        amag_reg   <= amag_next;
        aneg_reg   <= aneg_next;
        sel_up_reg <= sel_up_next;
        nltp_reg   <= nltp_next;
        num_reg    <= num_next;
        p_reg      <= p_next;
        nsh_reg    <= nsh_next;
        nmag_reg   <= nmag_next;
    end

endmodule

@@ hw/rtl/drtr_checker.sv @@
// Port-level checks for dual_ratio_test_ranging, bound to the top level.
// Depends on drtr_pkg.
`timescale 1ns / 1ps

module drtr_port_checks
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_up_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[80] |->
        m_tdata[63:0] == drtr_pkg::FIX_MAX && m_tdata[79:64] == 16'd0)
        else $error("up step without limiter not at maximum");

    a_dn_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[161] |->
        m_tdata[144:81] == drtr_pkg::FIX_MAX && m_tdata[160:145] == 16'd0)
        else $error("down step without limiter not at maximum");

endmodule

bind dual_ratio_test_ranging drtr_port_checks u_port_checks (.*);
